// ===== rtl/cdpa_pkg.sv =====
// Package for the clock divider pool allocator.
// Holds beat types, codes, controller states and the command/status structs.
// No dependencies.
package cdpa_pkg;

	localparam int CLK_W = 27;
	localparam int INT_W = 24;
	localparam int FRAC_W = 5;
	localparam int VAL_W = INT_W + FRAC_W;
	localparam int DIV_STEPS = CLK_W + FRAC_W;
	localparam int INT_STEPS = CLK_W;
	localparam logic [CLK_W-1:0] CLK_RESET = 27'd80000000;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_8    = 2'd0,
		KIND_16   = 2'd1,
		KIND_FRAC = 2'd2
	} kind_t;

	typedef struct packed {
		logic [9:0]       dest_index;
		logic [CLK_W-1:0] target_hz;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		kind_t             div_kind;
		logic [3:0]        div_slot;
		logic [INT_W-1:0]  int_value;
		logic [FRAC_W-1:0] frac_value;
	} out_item_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_CLASSIFY,
		S_READ,
		S_COMPARE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    clear_step;
		logic    load;
		logic    div_step;
		logic    classify;
		logic    scan_rd;
		logic    scan_next;
		logic    alloc;
		logic    record;
		logic    set_res;
		status_t res;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic div_last;
		logic bad;
		logic slot_free;
		logic slot_match;
		logic slot_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/cdpa_ctrl.sv =====
// Controller for the clock divider pool allocator.
// Sequences map clear, division, pool scan and result beat; uses cdpa_pkg.
module cdpa_ctrl import cdpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		cmd.res = ST_OK;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_CLASSIFY;
				end
			end
			S_CLASSIFY: begin
				cmd.classify = 1'b1;
				if (sts.bad) begin
					cmd.set_res = 1'b1;
					cmd.res = ST_BAD;
					state_n = S_DONE;
				end else begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				cmd.scan_rd = 1'b1;
				state_n = S_COMPARE;
			end
			S_COMPARE: begin
				if (sts.slot_free) begin
					cmd.alloc = 1'b1;
					cmd.record = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res = ST_OK;
					state_n = S_DONE;
				end else if (sts.slot_match) begin
					cmd.record = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res = ST_OK;
					state_n = S_DONE;
				end else if (sts.slot_last) begin
					cmd.set_res = 1'b1;
					cmd.res = ST_FULL;
					state_n = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_n = S_READ;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/cdpa_dp.sv =====
// Datapath for the clock divider pool allocator.
// Holds the clock register, bit-serial divider, pool store, destination map
// and output register; uses cdpa_pkg.
module cdpa_dp import cdpa_pkg::*; #(
	parameter int POOL8_SIZE    = 16,
	parameter int POOL16_SIZE   = 16,
	parameter int POOLFRAC_SIZE = 4,
	parameter int DEST_COUNT    = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CLK_W-1:0] cfg_wdata,
	input  in_item_t         in_data,
	input  logic             out_stall,
	output logic             out_valid,
	output out_item_t        out_data,
	input  cmd_t             cmd,
	output sts_t             sts
);

	localparam int TOTAL = POOL8_SIZE + POOL16_SIZE + POOLFRAC_SIZE;
	localparam int AW = $clog2(TOTAL);
	localparam int MAXP0 = (POOL8_SIZE > POOL16_SIZE) ? POOL8_SIZE : POOL16_SIZE;
	localparam int MAXP = (MAXP0 > POOLFRAC_SIZE) ? MAXP0 : POOLFRAC_SIZE;
	localparam int IW = (MAXP > 1) ? $clog2(MAXP) : 1;
	localparam int MW = $clog2(TOTAL + 1);
	localparam int DW = (DEST_COUNT > 1) ? $clog2(DEST_COUNT) : 1;
	localparam logic [AW-1:0] BASE16 = AW'(POOL8_SIZE);
	localparam logic [AW-1:0] BASEF = AW'(POOL8_SIZE + POOL16_SIZE);
	localparam logic [IW-1:0] LAST8 = IW'(POOL8_SIZE - 1);
	localparam logic [IW-1:0] LAST16 = IW'(POOL16_SIZE - 1);
	localparam logic [IW-1:0] LASTF = IW'(POOLFRAC_SIZE - 1);

	logic [CLK_W-1:0]     clk_hz_q;
	logic [9:0]           dest_q;
	logic [CLK_W-1:0]     tgt_q;
	logic [DIV_STEPS-1:0] dvd_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [CLK_W-1:0]     rem_q;
	logic [CLK_W-1:0]     r_q;
	logic [CLK_W+6:0]     r100_q;
	logic [4:0]           step_q;
	kind_t                kind_q;
	logic [INT_W-1:0]     ival_q;
	logic [FRAC_W-1:0]    fval_q;
	logic [VAL_W-1:0]     want_q;
	logic [AW-1:0]        base_q;
	logic [IW-1:0]        last_q;
	logic [IW-1:0]        idx_q;
	logic [VAL_W-1:0]     rd_q;
	status_t              res_q;
	logic [DW-1:0]        clr_q;
	logic [TOTAL-1:0]     en_q;
	logic [VAL_W-1:0]     val_mem [TOTAL];
	logic [MW-1:0]        map_mem [DEST_COUNT];
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [CLK_W:0]       trial;
	logic [CLK_W:0]       diff;
	logic                 ge;
	logic [CLK_W-1:0]     rem_n;
	logic [CLK_W-1:0]     q;
	logic                 use_frac;
	logic [INT_W-1:0]     ival_n;
	logic [AW-1:0]        addr;
	logic                 map_we;
	logic [DW-1:0]        map_addr;
	logic [MW-1:0]        map_wdata;
	logic                 dest_ok;
	out_item_t            out_n;

	assign trial = {rem_q, dvd_q[DIV_STEPS-1]};
	assign diff = trial - {1'b0, tgt_q};
	assign ge = trial >= {1'b0, tgt_q};
	assign rem_n = ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
	assign q = quo_q[DIV_STEPS-1:FRAC_W];
	assign use_frac = (q[CLK_W-1:16] != '0) || (r100_q > (CLK_W+7)'(tgt_q));
	assign ival_n = q[INT_W-1:0] - INT_W'(1);
	assign addr = base_q + AW'(idx_q);
	assign dest_ok = 32'(dest_q) < 32'(DEST_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	// divider: one quotient bit per step, remainder taken after the integer bits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dest_q <= in_data.dest_index;
			tgt_q <= in_data.target_hz;
			dvd_q <= {clk_hz_q, {FRAC_W{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
			step_q <= step_q + 5'd1;
			if (step_q == 5'(INT_STEPS - 1)) begin
				r_q <= rem_n;
			end
			if (step_q == 5'(INT_STEPS)) begin
				r100_q <= (CLK_W+7)'(r_q) * (CLK_W+7)'(100);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			idx_q <= '0;
			ival_q <= ival_n;
			if (use_frac) begin
				kind_q <= KIND_FRAC;
				fval_q <= quo_q[FRAC_W-1:0];
				want_q <= {ival_n, quo_q[FRAC_W-1:0]};
				base_q <= BASEF;
				last_q <= LASTF;
			end else if (q[CLK_W-1:8] == '0) begin
				kind_q <= KIND_8;
				fval_q <= '0;
				want_q <= VAL_W'(ival_n[7:0]);
				base_q <= '0;
				last_q <= LAST8;
			end else begin
				kind_q <= KIND_16;
				fval_q <= '0;
				want_q <= VAL_W'(ival_n[15:0]);
				base_q <= BASE16;
				last_q <= LAST16;
			end
		end else if (cmd.scan_next) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.set_res) begin
			res_q <= cmd.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (cmd.alloc) begin
			en_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			val_mem[addr] <= want_q;
		end
		if (cmd.scan_rd) begin
			rd_q <= val_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + DW'(1);
		end
	end

	assign map_we = cmd.clear_step || (cmd.record && dest_ok);
	assign map_addr = cmd.clear_step ? clr_q : DW'(dest_q);
	assign map_wdata = cmd.clear_step ? '0 : MW'(addr) + MW'(1);

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_addr] <= map_wdata;
		end
	end

	always_comb begin
		out_n.status = res_q;
		out_n.div_kind = kind_q;
		out_n.div_slot = '0;
		out_n.int_value = ival_q;
		out_n.frac_value = fval_q;
		case (res_q)
			ST_OK: begin
				out_n.div_slot = 4'(idx_q);
			end
			ST_FULL: begin
				out_n.div_slot = '0;
			end
			default: begin
				out_n.div_kind = KIND_8;
				out_n.int_value = '0;
				out_n.frac_value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign sts.clear_last = clr_q == DW'(DEST_COUNT - 1);
	assign sts.div_last = step_q == 5'(DIV_STEPS - 1);
	assign sts.bad = (tgt_q == '0) || (q == '0) || (q[CLK_W-1:INT_W] != '0);
	assign sts.slot_free = !en_q[addr];
	assign sts.slot_match = rd_q == want_q;
	assign sts.slot_last = idx_q == last_q;
	assign sts.out_busy = out_valid_q && out_stall;

endmodule

// ===== rtl/clock_divider_pool_allocator_unit.sv =====
// Clock divider pool allocator, top level; uses cdpa_pkg, cdpa_ctrl, cdpa_dp.
// Each item is loaded, run through the 32-step divider, classified and then
// matched against its pool slot by slot (read, then compare) before the result
// beat; a bad target skips the scan. One item is in progress at a time, and a
// stalled result beat holds back the next one. Reset: pools empty, clock
// register 80 MHz; all DEST_COUNT map entries are cleared before the first beat is taken.
module clock_divider_pool_allocator_unit import cdpa_pkg::*; #(
	parameter int POOL8_SIZE    = 16,
	parameter int POOL16_SIZE   = 16,
	parameter int POOLFRAC_SIZE = 4,
	parameter int DEST_COUNT    = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CLK_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	cmd_t cmd;
	sts_t sts;

	cdpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdpa_dp #(
		.POOL8_SIZE    (POOL8_SIZE),
		.POOL16_SIZE   (POOL16_SIZE),
		.POOLFRAC_SIZE (POOLFRAC_SIZE),
		.DEST_COUNT    (DEST_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without an item in progress");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_BAD |->
		out_data.div_slot == '0 && out_data.int_value == '0 && out_data.frac_value == '0)
		else $error("bad target beat carries nonzero fields");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.div_slot == '0)
		else $error("full pool beat carries a slot");

	a_int_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_kind != KIND_FRAC |-> out_data.frac_value == '0)
		else $error("integer pool beat carries a fraction");

endmodule
